FILE: sv/usm_pkg.sv
// Shared types, register codes, sine coefficients and Q15 helpers for the UV-sphere tessellator.
package usm_pkg;

    localparam int ITEM_W   = 16;
    localparam int COORD_W  = 16;
    localparam int RADIUS_W = 15;
    localparam int LEV_W    = 8;
    localparam int SLC_W    = 9;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVELS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLICES = 2'd2;

    localparam logic MODE_VERTEX   = 1'b0;
    localparam logic MODE_TRIANGLE = 1'b1;

    // phase dividers produce a 17-bit quotient (theta may reach a full turn)
    localparam int PH_QW = 17;
    localparam int PHASE_W = 16;
    localparam logic [PHASE_W-1:0] QUARTER_TURN = 16'h4000;

    // sine unit
    localparam int SIN_LAT = 7;
    localparam int SIN_W   = 25;
    localparam logic [SIN_W-1:0] SIN_C9 = 25'd2692;
    localparam logic [SIN_W-1:0] SIN_HORNER [4] = '{25'd78547, 25'd1337020,
                                                    25'd10837479, 25'd26353589};

    typedef struct packed {
        logic                mode;
        logic [ITEM_W-1:0]   item_number;
    } usm_in_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic signed [COORD_W-1:0] pos_z;
        logic [ITEM_W-1:0]         corner_a;
        logic [ITEM_W-1:0]         corner_b;
        logic [ITEM_W-1:0]         corner_c;
        logic                      out_of_range;
    } usm_out_t;

    // (a*b)/2^15, rounded half away from zero
    function automatic logic signed [17:0] mul_q15(input logic signed [17:0] a,
                                                   input logic signed [17:0] b);
        logic signed [35:0] p;
        logic [35:0]        m;
        logic [20:0]        r;
        logic signed [17:0] rs;
        p  = a * b;
        m  = p[35] ? 36'(-p) : 36'(p);
        r  = 21'((m + 36'd16384) >> 15);
        rs = $signed(18'(r));
        return p[35] ? -rs : rs;
    endfunction

endpackage

FILE: sv/usm_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module usm_div #(
    parameter int NW = 16,
    parameter int DW = 9,
    parameter int QW = 8
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo,
    output logic [DW-1:0] rem
);
    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic [CW-1:0] n_reg [QW];
    logic [DW-1:0] d_reg [QW];
    logic [QW-1:0] q_reg [QW];

    genvar s;
    for (s = 0; s < QW; s++) begin : g_stage
        logic [CW-1:0] n_in;
        logic [CW-1:0] dsh;
        logic [DW-1:0] d_in;
        logic [QW-1:0] q_in;
        if (s == 0) begin : g_first
            assign n_in = CW'(num);
            assign d_in = den;
            assign q_in = '0;
        end else begin : g_next
            assign n_in = n_reg[s-1];
            assign d_in = d_reg[s-1];
            assign q_in = q_reg[s-1];
        end
        assign dsh = CW'(d_in) << (QW - 1 - s);

        always_ff @(posedge aclk) begin
            if (en) begin
                d_reg[s] <= d_in;
                if (n_in >= dsh) begin
                    n_reg[s] <= n_in - dsh;
                    q_reg[s] <= q_in | (QW'(1) << (QW - 1 - s));
                end else begin
                    n_reg[s] <= n_in;
                    q_reg[s] <= q_in;
                end
            end
        end
    end

    assign quo = q_reg[QW-1];
    assign rem = n_reg[QW-1][DW-1:0];
endmodule

FILE: sv/usm_sin.sv
// Pipelined fixed-point sine of a 16-bit phase, Q15 result.
module usm_sin (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [15:0]           phase,
    output logic signed [17:0]    sin_q15
);
    import usm_pkg::*;

    logic [14:0]      t1_reg;
    logic             n1_reg;
    logic [14:0]      t2_reg;
    logic [14:0]      u2_reg;
    logic             n2_reg;
    logic [SIN_W-1:0] r_reg [4];
    logic [14:0]      th_reg [4];
    logic [14:0]      uh_reg [4];
    logic             nh_reg [4];
    logic [29:0]      tt;
    logic [39:0]      fin;
    logic [16:0]      s_mag;

    // quadrant fold
    always_ff @(posedge aclk) begin
        if (en) begin
            t1_reg <= phase[14] ? 15'(15'd16384 - 15'(phase[13:0])) : 15'(phase[13:0]);
            n1_reg <= phase[15];
        end
    end

    assign tt = 30'(t1_reg) * 30'(t1_reg);
    always_ff @(posedge aclk) begin
        if (en) begin
            t2_reg <= t1_reg;
            u2_reg <= 15'(tt >> 14);
            n2_reg <= n1_reg;
        end
    end

    // Horner steps
    genvar h;
    for (h = 0; h < 4; h++) begin : g_horner
        logic [SIN_W-1:0] r_in;
        logic [14:0]      t_in;
        logic [14:0]      u_in;
        logic             n_in;
        logic [39:0]      prod;
        if (h == 0) begin : g_first
            assign r_in = SIN_C9;
            assign t_in = t2_reg;
            assign u_in = u2_reg;
            assign n_in = n2_reg;
        end else begin : g_next
            assign r_in = r_reg[h-1];
            assign t_in = th_reg[h-1];
            assign u_in = uh_reg[h-1];
            assign n_in = nh_reg[h-1];
        end
        assign prod = 40'(r_in) * 40'(u_in);
        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[h]  <= SIN_HORNER[h] - SIN_W'(prod >> 14);
                th_reg[h] <= t_in;
                uh_reg[h] <= u_in;
                nh_reg[h] <= n_in;
            end
        end
    end

    assign fin   = 40'(r_reg[3]) * 40'(th_reg[3]) + 40'd4194304;
    assign s_mag = (fin[39:23] > 17'd32768) ? 17'd32768 : fin[39:23];

    always_ff @(posedge aclk) begin
        if (en) begin
            sin_q15 <= nh_reg[3] ? -$signed({1'b0, s_mag}) : $signed({1'b0, s_mag});
        end
    end

    // uh_reg of the last step feeds nothing further
    logic unused_u;
    assign unused_u = ^uh_reg[3];
endmodule

FILE: sv/uv_sphere_mesh_generator.sv
// UV-sphere tessellator top level: config registers, pipeline control and result assembly.
//
// Random-access UV-sphere tessellator. Each item asks for one vertex position (mode 0) or
// one triangle's three vertex indices (mode 1) and gives exactly one result. The block is
// a single stall-together pipeline that takes one item every cycle unless a result is
// held unaccepted on the output; it runs through the ring/column divider, the two 17-stage
// phase dividers, the 7-stage sine units and the two Q15 product stages. When a result
// sits on the output unaccepted, the whole pipeline holds and s_ready drops in the same
// cycle. Configuration registers (radius, levels, slices) are written through
// cfg_we/cfg_index/cfg_data and must only change while no item is in flight; out-of-range
// levels and slices are clamped.
module uv_sphere_mesh_generator #(
    parameter int MAX_LEVELS      = 128,
    parameter int MAX_SLICES      = 256,
    parameter int COORD_FRAC_BITS = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  usm_pkg::usm_in_t                     s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output usm_pkg::usm_out_t                    m_data,
    input  logic                                 cfg_we,
    input  logic [usm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [usm_pkg::RADIUS_W-1:0]         cfg_data
);
    import usm_pkg::*;

    localparam int QW1     = $clog2(MAX_LEVELS);          // ring row quotient bits
    localparam int DW1     = $clog2(MAX_SLICES + 2);      // ring width / column bits
    localparam int I_W     = QW1 + 1;                     // ring index bits
    localparam int PH_NW   = I_W + 16;
    localparam int TH_NW   = DW1 + 17;
    localparam int DW2     = $clog2(2 * MAX_LEVELS + 1);
    localparam int DW3     = $clog2(2 * MAX_SLICES + 1);
    localparam int SB2_LAT = PH_QW + SIN_LAT + 1;

    typedef struct packed {
        logic              vld;
        logic              mode;
        logic              oor;
        logic              first;   // top pole / top cap
        logic              last;    // bottom pole / bottom cap
        logic              odd;     // second triangle of a band quad
        logic [ITEM_W-1:0] item;
    } sb1_t;

    typedef struct packed {
        logic              vld;
        logic              mode;
        logic              oor;
        logic              pole_top;
        logic              pole_bot;
        logic [ITEM_W-1:0] ca;
        logic [ITEM_W-1:0] cb;
        logic [ITEM_W-1:0] cc;
    } sb2_t;

    // ---------------- configuration ----------------
    logic [RADIUS_W-1:0] radius_reg;
    logic [LEV_W-1:0]    levels_reg;
    logic [SLC_W-1:0]    slices_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_W'(1 << COORD_FRAC_BITS);
            levels_reg <= LEV_W'(8);
            slices_reg <= SLC_W'(16);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_RADIUS: radius_reg <= cfg_data;
                CFG_LEVELS: levels_reg <= cfg_data[LEV_W-1:0];
                CFG_SLICES: slices_reg <= cfg_data[SLC_W-1:0];
                default: ;
            endcase
        end
    end

    // clamped geometry; the user must keep it stable whenever items are in flight, the block does not enforce this
    logic [LEV_W-1:0]  l_eff;
    logic [SLC_W-1:0]  s_eff;
    logic [SLC_W-1:0]  w_eff;
    logic [ITEM_W-1:0] v_cnt;
    logic [ITEM_W-1:0] t_cnt;
    logic [ITEM_W-1:0] band_end;

    always_comb begin
        if (levels_reg == '0) l_eff = LEV_W'(1);
        else if (levels_reg > LEV_W'(MAX_LEVELS)) l_eff = LEV_W'(MAX_LEVELS);
        else l_eff = levels_reg;
        if (slices_reg < SLC_W'(3)) s_eff = SLC_W'(3);
        else if (slices_reg > SLC_W'(MAX_SLICES)) s_eff = SLC_W'(MAX_SLICES);
        else s_eff = slices_reg;
        w_eff    = s_eff + SLC_W'(1);
        v_cnt    = ITEM_W'(2) + ITEM_W'(l_eff - LEV_W'(1)) * ITEM_W'(w_eff);
        t_cnt    = (ITEM_W'(l_eff - LEV_W'(1)) * ITEM_W'(s_eff)) << 1;
        band_end = t_cnt - ITEM_W'(s_eff);
    end

    // ---------------- pipeline control ----------------
    logic     pipe_en;
    logic     m_valid_reg;
    usm_out_t m_data_reg;

    assign pipe_en = !m_valid_reg || m_ready;
    assign s_ready = pipe_en;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------- stage A: classify, set up row/column divide ----------------
    logic              a_vert;
    logic [ITEM_W-1:0] a_off;
    sb1_t              a_sb_next;
    sb1_t              a_sb_reg;
    logic [ITEM_W-1:0] a_num_reg;
    logic [DW1-1:0]    a_den_reg;

    always_comb begin
        a_vert          = (s_data.mode == MODE_VERTEX);
        a_off           = s_data.item_number - ITEM_W'(s_eff);
        a_sb_next.vld   = s_valid;
        a_sb_next.mode  = s_data.mode;
        a_sb_next.item  = s_data.item_number;
        a_sb_next.odd   = a_off[0];
        a_sb_next.oor   = a_vert ? (s_data.item_number >= v_cnt)
                                 : (s_data.item_number >= t_cnt);
        a_sb_next.first = a_vert ? (s_data.item_number == '0)
                                 : (s_data.item_number < ITEM_W'(s_eff));
        a_sb_next.last  = a_vert ? (s_data.item_number == v_cnt - ITEM_W'(1))
                                 : (s_data.item_number >= band_end);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_sb_reg.vld <= 1'b0;
        end else if (pipe_en) begin
            a_sb_reg  <= a_sb_next;
            a_num_reg <= a_vert ? s_data.item_number - ITEM_W'(1) : {1'b0, a_off[ITEM_W-1:1]};
            a_den_reg <= a_vert ? DW1'(w_eff) : DW1'(s_eff);
        end
    end

    logic [QW1-1:0] d1_quo;
    logic [DW1-1:0] d1_rem;

    usm_div #(.NW(ITEM_W), .DW(DW1), .QW(QW1)) u_div_ring (
        .aclk (aclk),
        .en   (pipe_en),
        .num  (a_num_reg),
        .den  (a_den_reg),
        .quo  (d1_quo),
        .rem  (d1_rem)
    );

    sb1_t sb1_reg [QW1];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < QW1; k++) sb1_reg[k].vld <= 1'b0;
        end else if (pipe_en) begin
            sb1_reg[0] <= a_sb_reg;
            for (int k = 1; k < QW1; k++) sb1_reg[k] <= sb1_reg[k-1];
        end
    end

    // ---------------- stage B: corners, phase numerators ----------------
    sb1_t              b_in;
    logic [I_W-1:0]    b_ring;
    logic [ITEM_W-1:0] b_jt;
    logic [ITEM_W-1:0] b_b0;
    logic [ITEM_W-1:0] b_b1;
    logic [ITEM_W-1:0] b_jb;
    logic [ITEM_W-1:0] b_base;
    sb2_t              b_sb_next;
    sb2_t              b_sb_reg;
    logic [PH_NW-1:0]  b_ph_num_reg;
    logic [TH_NW-1:0]  b_th_num_reg;
    logic [DW2-1:0]    b_ph_den_reg;
    logic [DW3-1:0]    b_th_den_reg;

    always_comb begin
        b_in   = sb1_reg[QW1-1];
        b_ring = {1'b0, d1_quo} + I_W'(1);
        b_jt   = ITEM_W'(d1_rem) + ITEM_W'(1);
        b_b0   = ITEM_W'(d1_quo) * ITEM_W'(w_eff);
        b_b1   = b_b0 + ITEM_W'(w_eff);
        b_jb   = b_in.item - band_end + ITEM_W'(1);
        b_base = v_cnt - ITEM_W'(2) - ITEM_W'(w_eff);

        b_sb_next.vld      = b_in.vld;
        b_sb_next.mode     = b_in.mode;
        b_sb_next.oor      = b_in.oor;
        b_sb_next.pole_top = b_in.first;
        b_sb_next.pole_bot = b_in.last;
        b_sb_next.ca       = '0;
        b_sb_next.cb       = '0;
        b_sb_next.cc       = '0;
        if (b_in.mode == MODE_TRIANGLE && !b_in.oor) begin
            if (b_in.first) begin
                b_sb_next.cb = b_in.item + ITEM_W'(2);
                b_sb_next.cc = b_in.item + ITEM_W'(1);
            end else if (b_in.last) begin
                b_sb_next.ca = b_base + b_jb;
                b_sb_next.cb = b_base + b_jb + ITEM_W'(1);
                b_sb_next.cc = v_cnt - ITEM_W'(1);
            end else if (!b_in.odd) begin
                b_sb_next.ca = b_b0 + b_jt;
                b_sb_next.cb = b_b0 + b_jt + ITEM_W'(1);
                b_sb_next.cc = b_b1 + b_jt + ITEM_W'(1);
            end else begin
                b_sb_next.ca = b_b1 + b_jt + ITEM_W'(1);
                b_sb_next.cb = b_b1 + b_jt;
                b_sb_next.cc = b_b0 + b_jt;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_sb_reg.vld <= 1'b0;
        end else if (pipe_en) begin
            b_sb_reg     <= b_sb_next;
            // phi phase = round(i*32768/L), theta phase = round(j*65536/S)
            b_ph_num_reg <= {b_ring, 16'b0} + PH_NW'(l_eff);
            b_th_num_reg <= {d1_rem, 17'b0} + TH_NW'(s_eff);
            b_ph_den_reg <= DW2'(l_eff) << 1;
            b_th_den_reg <= DW3'(s_eff) << 1;
        end
    end

    logic [PH_QW-1:0] phi_quo;
    logic [PH_QW-1:0] th_quo;
    logic [DW2-1:0]   phi_rem;
    logic [DW3-1:0]   th_rem;

    usm_div #(.NW(PH_NW), .DW(DW2), .QW(PH_QW)) u_div_phi (
        .aclk (aclk),
        .en   (pipe_en),
        .num  (b_ph_num_reg),
        .den  (b_ph_den_reg),
        .quo  (phi_quo),
        .rem  (phi_rem)
    );

    usm_div #(.NW(TH_NW), .DW(DW3), .QW(PH_QW)) u_div_theta (
        .aclk (aclk),
        .en   (pipe_en),
        .num  (b_th_num_reg),
        .den  (b_th_den_reg),
        .quo  (th_quo),
        .rem  (th_rem)
    );

    logic unused_rem;
    assign unused_rem = ^{phi_rem, th_rem, phi_quo[PH_QW-1], th_quo[PH_QW-1]};

    // ---------------- trig ----------------
    logic [PHASE_W-1:0] phi_ph;
    logic [PHASE_W-1:0] th_ph;
    logic signed [17:0] sin_phi;
    logic signed [17:0] cos_phi;
    logic signed [17:0] sin_th;
    logic signed [17:0] cos_th;

    assign phi_ph = phi_quo[PHASE_W-1:0];
    assign th_ph  = th_quo[PHASE_W-1:0];   // full turn wraps to zero

    usm_sin u_sin_phi (.aclk(aclk), .en(pipe_en), .phase(phi_ph), .sin_q15(sin_phi));
    usm_sin u_cos_phi (.aclk(aclk), .en(pipe_en), .phase(phi_ph + QUARTER_TURN),
                       .sin_q15(cos_phi));
    usm_sin u_sin_th  (.aclk(aclk), .en(pipe_en), .phase(th_ph), .sin_q15(sin_th));
    usm_sin u_cos_th  (.aclk(aclk), .en(pipe_en), .phase(th_ph + QUARTER_TURN),
                       .sin_q15(cos_th));

    // ---------------- M1: sin(phi) * cos/sin(theta) ----------------
    logic signed [17:0] spct_reg;
    logic signed [17:0] spst_reg;
    logic signed [17:0] cp_reg;

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            spct_reg <= mul_q15(sin_phi, cos_th);
            spst_reg <= mul_q15(sin_phi, sin_th);
            cp_reg   <= cos_phi;
        end
    end

    sb2_t sb2_reg [SB2_LAT];
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < SB2_LAT; k++) sb2_reg[k].vld <= 1'b0;
        end else if (pipe_en) begin
            sb2_reg[0] <= b_sb_reg;
            for (int k = 1; k < SB2_LAT; k++) sb2_reg[k] <= sb2_reg[k-1];
        end
    end

    // ---------------- M2: scale by radius, assemble result ----------------
    sb2_t               o_sb;
    logic signed [17:0] radius_s;
    usm_out_t           o_next;

    always_comb begin
        o_sb     = sb2_reg[SB2_LAT-1];
        radius_s = $signed({3'b0, radius_reg});
        o_next   = '0;
        if (o_sb.oor) begin
            o_next.out_of_range = 1'b1;
        end else if (o_sb.mode == MODE_VERTEX) begin
            if (o_sb.pole_top) begin
                o_next.pos_y = COORD_W'(radius_s);
            end else if (o_sb.pole_bot) begin
                o_next.pos_y = COORD_W'(-radius_s);
            end else begin
                o_next.pos_x = COORD_W'(mul_q15(radius_s, spct_reg));
                o_next.pos_y = COORD_W'(mul_q15(radius_s, cp_reg));
                o_next.pos_z = COORD_W'(mul_q15(radius_s, spst_reg));
            end
        end else begin
            o_next.corner_a = o_sb.ca;
            o_next.corner_b = o_sb.cb;
            o_next.corner_c = o_sb.cc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            m_valid_reg <= o_sb.vld;
            m_data_reg  <= o_next;
        end
    end

    // ---------------- assertions ----------------
    // out-of-range results carry nothing but the flag
    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.out_of_range |-> m_data.pos_x == '0 && m_data.pos_y == '0 &&
            m_data.pos_z == '0 && m_data.corner_a == '0 && m_data.corner_b == '0 &&
            m_data.corner_c == '0)
        else $error("out-of-range item with nonzero fields");

    // a held output freezes the front of the pipeline
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |=> $stable(a_sb_reg) && $stable(b_sb_reg))
        else $error("pipeline moved during stall");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");
endmodule

FILE: bench/tb_uv_sphere_mesh_generator.sv
// Self-checking bench for the UV-sphere tessellator: vertex positions and triangle corners.
module tb_uv_sphere_mesh_generator;
    import usm_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 80;   // well past the pipeline depth

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    usm_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    usm_out_t m_data;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_RADIUS;
    logic [RADIUS_W-1:0]  cfg_data = '0;

    uv_sphere_mesh_generator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Local copy of the register file, as written (clamping happens in the predictor)
    int unsigned radius_reg = 256;
    int unsigned levels_reg = 8;
    int unsigned slices_reg = 16;

    usm_out_t expected_results[$];
    int  mismatch_count = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  recv_hold_left = 0;    // long receiver stall, counted down by the receiver
    int  stalled_cycles = 0;    // cycles since anything was accepted

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // Predictor: fixed-point trig and mesh indexing
    // ---------------------------------------------------------------

    // Q15 sine of a 16-bit phase via quadrant fold and degree-9 Horner
    function automatic longint phase_sine(int unsigned ph);
        int unsigned q, p;
        longint t, u, r, s;
        q = (ph >> 14) & 3;
        p = ph & 16'h3FFF;
        t = q[0] ? longint'(16384 - p) : longint'(p);
        u = (t * t) >>> 14;
        r = 2692;
        r = 78547    - ((r * u) >>> 14);
        r = 1337020  - ((r * u) >>> 14);
        r = 10837479 - ((r * u) >>> 14);
        r = 26353589 - ((r * u) >>> 14);
        s = (r * t + (64'sd1 <<< 22)) >>> 23;
        if (s > 32768) s = 32768;
        return q[1] ? -s : s;
    endfunction

    // product scaled down by 2^15, rounded half away from zero
    function automatic longint q15_product(longint a, longint b);
        longint p, m, r;
        p = a * b;
        m = (p < 0) ? -p : p;
        r = (m + 16384) >>> 15;
        return (p < 0) ? -r : r;
    endfunction

    function automatic usm_out_t predict_mesh_item(usm_in_t req);
        usm_out_t res;
        int unsigned lev, slc, cols, nverts, ntris, item, m, ri, cj;
        int unsigned phi_ph, theta_ph, band, quad, b0, b1, ca, cb, cc;
        longint rad, sp, cp, st, ct;
        res  = '0;
        lev  = levels_reg;
        slc  = slices_reg;
        if (lev < 1)          lev = 1;
        if (lev > 128)        lev = 128;
        if (slc < 3)          slc = 3;
        if (slc > 256)        slc = 256;
        cols   = slc + 1;
        nverts = 2 + (lev - 1) * cols;
        ntris  = 2 * (lev - 1) * slc;
        item   = req.item_number;
        rad    = radius_reg;
        if (req.mode == MODE_VERTEX) begin
            if (item >= nverts) begin
                res.out_of_range = 1'b1;
            end else if (item == 0) begin
                res.pos_y = 16'(rad);
            end else if (item == nverts - 1) begin
                res.pos_y = 16'(-rad);
            end else begin
                m  = item - 1;
                ri = m / cols + 1;
                cj = m % cols;
                phi_ph   = (ri * 65536 + lev) / (2 * lev);
                theta_ph = int'((longint'(cj) * 131072 + slc) / (2 * slc)) & 16'hFFFF;
                sp = phase_sine(phi_ph);
                cp = phase_sine((phi_ph + 16384) & 16'hFFFF);
                st = phase_sine(theta_ph);
                ct = phase_sine((theta_ph + 16384) & 16'hFFFF);
                res.pos_x = 16'(q15_product(rad, q15_product(sp, ct)));
                res.pos_y = 16'(q15_product(rad, cp));
                res.pos_z = 16'(q15_product(rad, q15_product(sp, st)));
            end
        end else begin
            if (item >= ntris) begin
                res.out_of_range = 1'b1;
            end else begin
                band = 2 * (lev - 1) * slc - 2 * slc;
                if (item < slc) begin
                    // top cap fans out of the pole
                    ca = 0; cb = item + 2; cc = item + 1;
                end else if (item < slc + band) begin
                    quad = (item - slc) >> 1;
                    ri = quad / slc + 1;
                    cj = quad % slc + 1;
                    b0 = (ri - 1) * cols;
                    b1 = ri * cols;
                    if (((item - slc) & 1) == 0) begin
                        ca = b0 + cj; cb = b0 + cj + 1; cc = b1 + cj + 1;
                    end else begin
                        ca = b1 + cj + 1; cb = b1 + cj; cc = b0 + cj;
                    end
                end else begin
                    // bottom cap closes on the last vertex
                    cj = item - slc - band + 1;
                    b0 = (lev - 2) * cols;
                    ca = b0 + cj; cb = b0 + cj + 1; cc = nverts - 1;
                end
                res.corner_a = 16'(ca);
                res.corner_b = 16'(cb);
                res.corner_c = 16'(cc);
            end
        end
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Receiver, result checker and watchdog
    // ---------------------------------------------------------------

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d (t=%0t)", field, got, want, $time);
        mismatch_count++;
    endtask

    // m_ready changes only at the rising edge; a long hold-off overrides the random idling
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (recv_hold_left > 0) begin
            m_ready <= 1'b0;
            recv_hold_left <= recv_hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Sample mid-cycle: whatever is seen here is what the next rising edge accepts
    always @(negedge aclk) begin
        usm_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = expected_results.pop_front();
                if (m_data.pos_x != want.pos_x)
                    report_mismatch("pos_x", m_data.pos_x, want.pos_x);
                if (m_data.pos_y != want.pos_y)
                    report_mismatch("pos_y", m_data.pos_y, want.pos_y);
                if (m_data.pos_z != want.pos_z)
                    report_mismatch("pos_z", m_data.pos_z, want.pos_z);
                if (m_data.corner_a != want.corner_a)
                    report_mismatch("corner_a", m_data.corner_a, want.corner_a);
                if (m_data.corner_b != want.corner_b)
                    report_mismatch("corner_b", m_data.corner_b, want.corner_b);
                if (m_data.corner_c != want.corner_c)
                    report_mismatch("corner_c", m_data.corner_c, want.corner_c);
                if (m_data.out_of_range != want.out_of_range)
                    report_mismatch("out_of_range", m_data.out_of_range, want.out_of_range);
            end
        end
    end

    // counts edges at which neither channel accepts an item
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stalled_cycles <= 0;
        end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            stalled_cycles <= stalled_cycles + 1;
        end
    end

    // ---------------------------------------------------------------
    // Shared driver tasks
    // ---------------------------------------------------------------

    // Offer one item; the expectation is queued at the cycle it is taken
    task automatic send_item(logic mode, int unsigned num);
        usm_in_t req;
        req.mode = mode;
        req.item_number = 16'(num);
        if ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(negedge aclk); while (!s_ready);
        expected_results.push_back(predict_mesh_item(req));
        @(posedge aclk);
    endtask

    // Drop valid and wait for the pipeline to empty out
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= RADIUS_W'(val);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_RADIUS: radius_reg = val & 16'h7FFF;
            CFG_LEVELS: levels_reg = val & 8'hFF;
            default:    slices_reg = val & 9'h1FF;
        endcase
    endtask

    task automatic set_mesh(int unsigned rad, int unsigned lev, int unsigned slc);
        wait_drained();
        write_reg(CFG_RADIUS, rad);
        write_reg(CFG_LEVELS, lev);
        write_reg(CFG_SLICES, slc);
        @(posedge aclk);
    endtask

    function automatic int unsigned vertex_count();
        int unsigned lev, slc;
        lev = (levels_reg < 1) ? 1 : (levels_reg > 128) ? 128 : levels_reg;
        slc = (slices_reg < 3) ? 3 : (slices_reg > 256) ? 256 : slices_reg;
        return 2 + (lev - 1) * (slc + 1);
    endfunction

    function automatic int unsigned triangle_count();
        int unsigned lev, slc;
        lev = (levels_reg < 1) ? 1 : (levels_reg > 128) ? 128 : levels_reg;
        slc = (slices_reg < 3) ? 3 : (slices_reg > 256) ? 256 : slices_reg;
        return 2 * (lev - 1) * slc;
    endfunction

    // Random item: mostly inside the mesh, some at its edge, some anywhere in 16 bits
    task automatic send_random_item();
        logic mode;
        int unsigned lim, pick, num;
        mode = 1'($urandom_range(1));
        lim = (mode == MODE_VERTEX) ? vertex_count() : triangle_count();
        pick = $urandom_range(99);
        if (pick < 70 && lim > 0)      num = $urandom_range(lim - 1);
        else if (pick < 85)            num = lim + $urandom_range(2) - 1;
        else                           num = $urandom_range(65535);
        send_item(mode, num & 16'hFFFF);
    endtask

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Reset geometry: top pole, first ring, caps, band and both out-of-range edges
    task automatic test_reset_mesh();
        send_item(MODE_VERTEX, 0);
        send_item(MODE_VERTEX, 1);
        send_item(MODE_VERTEX, 17);           // seam duplicate of column 0
        send_item(MODE_VERTEX, 121);          // first vertex beyond the mesh, V = 2 + 7*17
        send_item(MODE_VERTEX, 122);          // second vertex beyond the mesh
        send_item(MODE_TRIANGLE, 0);          // top cap
        send_item(MODE_TRIANGLE, 16);         // first band triangle
        send_item(MODE_TRIANGLE, 17);         // its partner
        send_item(MODE_TRIANGLE, 223);        // last bottom-cap triangle
        send_item(MODE_TRIANGLE, 224);        // first triangle beyond the mesh
        send_item(MODE_TRIANGLE, 65535);
        send_item(MODE_VERTEX, 65535);
    endtask

    // Register extremes, including clamped levels and slices
    task automatic test_register_extremes();
        set_mesh(0, 1, 3);                    // single level: only the poles
        send_item(MODE_VERTEX, 0);
        send_item(MODE_VERTEX, 1);
        send_item(MODE_TRIANGLE, 0);
        set_mesh(32767, 0, 0);                // levels and slices below range
        send_item(MODE_VERTEX, 1);
        send_item(MODE_TRIANGLE, 0);
        set_mesh(32767, 2, 256);              // no band quads, widest ring
        send_item(MODE_VERTEX, 129);
        send_item(MODE_TRIANGLE, 511);
        set_mesh(32767, 255, 511);            // above range: act as 128 x 256
        send_item(MODE_VERTEX, 32640);
        send_item(MODE_VERTEX, 16500);
        send_item(MODE_TRIANGLE, 65023);
        send_item(MODE_TRIANGLE, 65024);
        set_mesh(256, 128, 3);
    endtask

    // Random geometry; several settings per idling profile
    task automatic test_random_mesh(int sender_pct, int receiver_pct, int settings);
        int unsigned lev, slc;
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        for (int k = 0; k < settings; k++) begin
            lev = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(1, 12);
            slc = ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(0, 24);
            set_mesh($urandom_range(32767), lev, slc);
            repeat (60) send_random_item();
            // let the sender sit out until everything has come back, then continue
            if (k == 1) wait_drained();
            repeat (20) send_random_item();
        end
    endtask

    // Receiver stalls long enough that the pipeline fills and s_ready drops
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_mesh(20000, 6, 9);
        recv_hold_left = 300;
        repeat (80) send_random_item();
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_mesh();
        test_register_extremes();
        test_random_mesh(38, 69, 3);
        test_random_mesh(69, 38, 3);
        test_random_mesh(0, 0, 2);
        test_output_backpressure();

        wait_drained();
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
